// File: rtl/srt_pkg.sv
// Shared types and constants for the SSA rename table.
// Used by srt_table, srt_alu and ssa_rename_table_core; no dependencies.
package srt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int CMD_W = 2;
  localparam int KEY_W = 10;
  localparam int SSA_W = 15;
  localparam int NUM_W = 16;

  localparam logic [CMD_W-1:0] CMD_MARK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RENAME = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DUMP   = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [SSA_W-1:0] start;
    logic [NUM_W-1:0] end_num;
    logic [SSA_W-1:0] oldc;
  } entry_t;

  // Write request from the sequencer to the table
  typedef struct packed {
    logic             we;
    logic             insert;
    logic             clear;
    logic [IDX_W-1:0] idx;
    entry_t           data;
  } tbl_wr_t;

  typedef struct packed {
    logic             key_eq;
    logic             below;
    logic [NUM_W-1:0] nn;
    logic             raise;
  } alu_res_t;

endpackage

// File: rtl/srt_table.sv
// Entry storage of the rename table: key/start/end/old-count rows and fill count.
// Depends on srt_pkg.
module srt_table
  import srt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] rd_idx,
  output entry_t           rd_entry,
  input  tbl_wr_t          wr,
  output logic [CNT_W-1:0] count
);

  entry_t           rows_r [TABLE_DEPTH];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [IDX_W-1:0] wr_idx;

  assign wr_idx   = wr.insert ? count_r[IDX_W-1:0] : wr.idx;
  assign rd_entry = rows_r[rd_idx];
  assign count    = count_r;

  always_comb begin
    count_nxt = count_r;
    if (wr.clear) begin
      count_nxt = '0;
    end else if (wr.we && wr.insert) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // rows carry no reset; only rows below the fill count are ever used
  always_ff @(posedge clk) begin
    if (wr.we && !wr.clear) begin
      rows_r[wr_idx] <= wr.data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.we && wr.insert) |-> (count_r < CNT_W'(TABLE_DEPTH)))
    else $error("insert into full table");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    wr.clear |=> (count_r == '0))
    else $error("clear left entries");

endmodule

// File: rtl/srt_alu.sv
// Shared compare/add unit: key match during the scan, order check and
// renamed number during the update. Depends on srt_pkg.
module srt_alu
  import srt_pkg::*;
(
  input  logic [KEY_W-1:0] key,
  input  logic [SSA_W-1:0] ssa,
  input  entry_t           ent,
  output alu_res_t         res
);

  logic [NUM_W:0] sum;

  // ssa + 1 + old count - start; fits in 16 bits whenever ssa >= start
  assign sum = {2'b00, ssa} + (NUM_W+1)'(1) + {2'b00, ent.oldc} - {2'b00, ent.start};

  assign res.key_eq = (key == ent.key);
  assign res.below  = (ssa < ent.start);
  assign res.nn     = sum[NUM_W-1:0];
  assign res.raise  = (sum[NUM_W-1:0] > ent.end_num);

endmodule

// File: rtl/ssa_rename_table_core.sv
// SSA rename table top level: stream ports, command sequencer, output register.
// Depends on srt_pkg, srt_table and srt_alu.
//
// Usage:
//   One command per input transfer on in_*: in_tuser is the command (mark lowest,
//   rename, clear, dump), in_tdata carries the key, SSA number and old variable
//   count. Results leave on out_* with out_tlast set on the final result of a
//   command; every command gives one result except dump, which gives one per
//   stored entry (or a single empty result when the table holds nothing).
//   Mark and rename walk the stored keys one per cycle through a single compare
//   unit, then do the update, which waits while the result register is full.
//   Clear goes straight to the update; dump loads one result per stored entry,
//   each when the result register is free. in_tready is high only while no
//   command is in progress, so a new command can be taken in the cycle after
//   the last result loads. The result register frees the sequencer: the next
//   command can be accepted while the last result still waits. When the receiver
//   stalls, the sequencer holds at its next result until the register drains.
//   Reset (rst_n low, synchronous) empties the table and drops any result.
module ssa_rename_table_core
  import srt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // reg_index[9:0], ssa_num[24:10], old_var_count[39:25]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // new_ssa_num[15:0], dump_index[25:16], dump_end_num[41:26]
  output logic [3:0]  out_tuser,  // hit[0], order_error[1], overflow[2], dump_valid[3]
  output logic        out_tlast
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;
  localparam logic [1:0] ST_DUMP   = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             hit_r, hit_nxt;
  logic [CMD_W-1:0] cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [SSA_W-1:0] ssa_r;
  logic [SSA_W-1:0] oldc_r;

  logic             out_valid_r, out_valid_nxt;
  logic [NUM_W-1:0] o_new_r, o_new_nxt;
  logic             o_hit_r, o_hit_nxt;
  logic             o_err_r, o_err_nxt;
  logic             o_ovf_r, o_ovf_nxt;
  logic [KEY_W-1:0] o_didx_r, o_didx_nxt;
  logic [NUM_W-1:0] o_dend_r, o_dend_nxt;
  logic             o_dval_r, o_dval_nxt;
  logic             o_last_r, o_last_nxt;

  logic             in_fire;
  logic             out_free;
  logic             out_load;
  logic             full;
  logic [NUM_W-1:0] ins_num;
  entry_t           rd_entry;
  tbl_wr_t          wr;
  alu_res_t         alu;
  logic [CNT_W-1:0] count;

  srt_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (idx_r[IDX_W-1:0]),
    .rd_entry (rd_entry),
    .wr       (wr),
    .count    (count)
  );

  srt_alu u_alu (
    .key (key_r),
    .ssa (ssa_r),
    .ent (rd_entry),
    .res (alu)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign full      = (count == CNT_W'(TABLE_DEPTH));
  assign ins_num   = {1'b0, oldc_r} + NUM_W'(1);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    hit_nxt       = hit_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    o_new_nxt     = '0;
    o_hit_nxt     = 1'b0;
    o_err_nxt     = 1'b0;
    o_ovf_nxt     = 1'b0;
    o_didx_nxt    = '0;
    o_dend_nxt    = '0;
    o_dval_nxt    = 1'b0;
    o_last_nxt    = 1'b1;
    wr            = '0;
    wr.idx        = idx_r[IDX_W-1:0];
    wr.data       = rd_entry;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          idx_nxt = '0;
          hit_nxt = 1'b0;
          unique case (in_tuser)
            CMD_MARK, CMD_RENAME: state_nxt = ST_SCAN;
            CMD_CLEAR:            state_nxt = ST_UPDATE;
            default:              state_nxt = ST_DUMP;
          endcase
        end
      end
      ST_SCAN: begin
        if (idx_r == count) begin
          state_nxt = ST_UPDATE;
        end else if (alu.key_eq) begin
          hit_nxt   = 1'b1;
          state_nxt = ST_UPDATE;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
          o_hit_nxt = hit_r && (cmd_r != CMD_CLEAR);
          priority if (cmd_r == CMD_CLEAR) begin
            wr.clear = 1'b1;
          end else if (hit_r) begin
            if (cmd_r == CMD_MARK) begin
              if (alu.below) begin
                wr.we           = 1'b1;
                wr.data.start   = ssa_r;
                wr.data.end_num = {1'b0, ssa_r};
              end
            end else if (alu.below) begin
              o_err_nxt = 1'b1;
            end else begin
              o_new_nxt = alu.nn;
              if (alu.raise) begin
                wr.we           = 1'b1;
                wr.data.end_num = alu.nn;
              end
            end
          end else if (full) begin
            o_ovf_nxt = 1'b1;
          end else begin
            wr.we         = 1'b1;
            wr.insert     = 1'b1;
            wr.data.key   = key_r;
            wr.data.start = ssa_r;
            wr.data.oldc  = oldc_r;
            if (cmd_r == CMD_MARK) begin
              wr.data.end_num = {1'b0, ssa_r};
            end else begin
              wr.data.end_num = ins_num;
              o_new_nxt       = ins_num;
            end
          end
        end
      end
      default: begin
        // dump: one entry per transfer, in insertion order
        if (out_free) begin
          out_load   = 1'b1;
          o_dval_nxt = (count != '0);
          o_didx_nxt = (count != '0) ? rd_entry.key : '0;
          o_dend_nxt = (count != '0) ? rd_entry.end_num : '0;
          o_last_nxt = (count == '0) || (idx_r + CNT_W'(1) == count);
          if (o_last_nxt) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r  <= in_tuser;
      key_r  <= in_tdata[9:0];
      ssa_r  <= in_tdata[24:10];
      oldc_r <= in_tdata[39:25];
    end
    if (out_load) begin
      o_new_r  <= o_new_nxt;
      o_hit_r  <= o_hit_nxt;
      o_err_r  <= o_err_nxt;
      o_ovf_r  <= o_ovf_nxt;
      o_didx_r <= o_didx_nxt;
      o_dend_r <= o_dend_nxt;
      o_dval_r <= o_dval_nxt;
      o_last_r <= o_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, o_dend_r, o_didx_r, o_new_r};
  assign out_tuser  = {o_dval_r, o_ovf_r, o_err_r, o_hit_r};
  assign out_tlast  = o_last_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("ready while a command is in progress");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (idx_r <= count))
    else $error("scan index past fill count");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && o_last_nxt) |=> (state_r == ST_IDLE))
    else $error("sequencer busy after final result");

  a_write_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.we || wr.clear) |-> (out_load && state_r == ST_UPDATE))
    else $error("table written without a result");

endmodule

// File: verif/ssa_rename_table_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for ssa_rename_table_core: directed table plus random commands,
// checked against a shadow copy of the rename table. Depends on srt_pkg and the RTL.
module ssa_rename_table_core_test;
  import srt_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 4;
  localparam int NPH          = 5;

  typedef struct packed {
    logic [NUM_W-1:0] new_num;
    logic             hit;
    logic             order_err;
    logic             ovf;
    logic [KEY_W-1:0] d_idx;
    logic [NUM_W-1:0] d_end;
    logic             d_val;
    logic             last;
  } rename_res_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [SSA_W-1:0] ssa;
    logic [SSA_W-1:0] oldc;
    bit               typed;
    rename_res_t      want;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // reg_index[9:0], ssa_num[24:10], old_var_count[39:25]
  logic [1:0]  in_tuser;   // cmd[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // new_ssa_num[15:0], dump_index[25:16], dump_end_num[41:26]
  logic [3:0]  out_tuser;  // hit[0], order_error[1], overflow[2], dump_valid[3]
  logic        out_tlast;

  ssa_rename_table_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // shadow copy of the rename table
  int               shadow_count;
  logic [KEY_W-1:0] shadow_key   [TABLE_DEPTH];
  logic [SSA_W-1:0] shadow_start [TABLE_DEPTH];
  logic [NUM_W-1:0] shadow_end   [TABLE_DEPTH];
  logic [SSA_W-1:0] shadow_oldc  [TABLE_DEPTH];

  rename_res_t pending_results[$];
  dir_row_t    dir_rows[$];
  logic [KEY_W-1:0] key_pool[20];

  int  fail_cnt;
  int  n_checked;
  int  n_sent;
  int  cmd_seen[4];
  int  n_hit, n_err, n_ovf, n_full_dump;
  int  src_idle_pct;
  int  sink_stall_pct;
  bit  hold_token;
  bit  hold_seen;
  int  hold_left;
  int  cycle_cnt;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic rename_res_t mk_res(input logic [NUM_W-1:0] nn, input logic h,
                                         input logic e, input logic o, input logic dv);
    rename_res_t r;
    r = '0;
    r.new_num = nn;
    r.hit = h;
    r.order_err = e;
    r.ovf = o;
    r.d_val = dv;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic int find_slot(input logic [KEY_W-1:0] key);
    int i;
    for (i = 0; i < shadow_count; i++)
      if (shadow_key[i] == key) return i;
    return -1;
  endfunction

  task automatic add_row(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] key,
                         input logic [SSA_W-1:0] ssa, input logic [SSA_W-1:0] oldc,
                         input bit typed, input rename_res_t want);
    dir_row_t row;
    row.cmd = c;
    row.key = key;
    row.ssa = ssa;
    row.oldc = oldc;
    row.typed = typed;
    row.want = want;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // Updates the shadow table for one accepted command; queues its results when asked.
  task automatic rename_predict(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] key,
                                input logic [SSA_W-1:0] ssa, input logic [SSA_W-1:0] oldc,
                                input bit push);
    rename_res_t r;
    int slot;
    int i;
    logic [NUM_W-1:0] nn;
    r = '0;
    r.last = 1'b1;
    slot = find_slot(key);
    cmd_seen[c]++;
    case (c)
      CMD_MARK: begin
        if (slot >= 0) begin
          r.hit = 1'b1;
          if (ssa < shadow_start[slot]) begin
            shadow_start[slot] = ssa;
            shadow_end[slot] = {1'b0, ssa};
          end
        end else if (shadow_count < TABLE_DEPTH) begin
          shadow_key[shadow_count] = key;
          shadow_start[shadow_count] = ssa;
          shadow_end[shadow_count] = {1'b0, ssa};
          shadow_oldc[shadow_count] = oldc;
          shadow_count++;
        end else begin
          r.ovf = 1'b1;
        end
      end
      CMD_RENAME: begin
        if (slot >= 0) begin
          r.hit = 1'b1;
          if (ssa < shadow_start[slot]) begin
            r.order_err = 1'b1;
          end else begin
            nn = {1'b0, ssa} + 16'd1 + {1'b0, shadow_oldc[slot]} - {1'b0, shadow_start[slot]};
            if (nn > shadow_end[slot]) shadow_end[slot] = nn;
            r.new_num = nn;
          end
        end else begin
          nn = {1'b0, oldc} + 16'd1;
          if (shadow_count < TABLE_DEPTH) begin
            shadow_key[shadow_count] = key;
            shadow_start[shadow_count] = ssa;
            shadow_end[shadow_count] = nn;
            shadow_oldc[shadow_count] = oldc;
            shadow_count++;
            r.new_num = nn;
          end else begin
            r.ovf = 1'b1;
          end
        end
      end
      CMD_CLEAR: shadow_count = 0;
      default: ;
    endcase
    n_hit += int'(r.hit);
    n_err += int'(r.order_err);
    n_ovf += int'(r.ovf);
    if (c == CMD_DUMP && shadow_count > 0) begin
      if (shadow_count == TABLE_DEPTH) n_full_dump++;
      for (i = 0; i < shadow_count; i++) begin
        r = '0;
        r.d_idx = shadow_key[i];
        r.d_end = shadow_end[i];
        r.d_val = 1'b1;
        r.last = (i == shadow_count - 1);
        if (push) pending_results.insert(pending_results.size(), r);
      end
    end else if (push) begin
      pending_results.insert(pending_results.size(), r);
    end
  endtask

  // Offers one command, waits for its transfer; called at a rising edge.
  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] key,
                          input logic [SSA_W-1:0] ssa, input logic [SSA_W-1:0] oldc);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= {oldc, ssa, key};
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  task automatic check_field(input string name, input logic [NUM_W-1:0] want,
                             input logic [NUM_W-1:0] got);
    if (want !== got) begin
      fail_cnt++;
      if (fail_cnt <= 30)
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    rename_res_t want;
    rename_res_t got;
    got.new_num   = out_tdata[15:0];
    got.d_idx     = out_tdata[25:16];
    got.d_end     = out_tdata[41:26];
    got.hit       = out_tuser[0];
    got.order_err = out_tuser[1];
    got.ovf       = out_tuser[2];
    got.d_val     = out_tuser[3];
    got.last      = out_tlast;
    if (pending_results.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= 30)
        $display("%0t: unexpected result, expected none actual tdata %h tuser %h tlast %b",
                 $time, out_tdata, out_tuser, out_tlast);
    end else begin
      want = pending_results.pop_front();
      check_field("new_ssa_num", want.new_num, got.new_num);
      check_field("hit", NUM_W'(want.hit), NUM_W'(got.hit));
      check_field("order_error", NUM_W'(want.order_err), NUM_W'(got.order_err));
      check_field("overflow", NUM_W'(want.ovf), NUM_W'(got.ovf));
      check_field("dump_index", NUM_W'(want.d_idx), NUM_W'(got.d_idx));
      check_field("dump_end_num", want.d_end, got.d_end);
      check_field("dump_valid", NUM_W'(want.d_val), NUM_W'(got.d_val));
      check_field("last", NUM_W'(want.last), NUM_W'(got.last));
      n_checked++;
    end
  endtask

  // result side: check transfers, then choose the next tready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_result();
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("ssa_rename_table_core regression: fail");
      $finish;
    end
  end

  initial begin
    int ph_src  [NPH];
    int ph_sink [NPH];
    int ph_items[NPH];
    int k, p, roll, slot;
    logic [CMD_W-1:0] c;
    logic [KEY_W-1:0] key;
    logic [SSA_W-1:0] ssa, oldc;

    ph_src   = '{0, 55, 0, 6, 0};
    ph_sink  = '{0, 0, 55, 6, 0};
    ph_items = '{55, 55, 55, 55, 30};
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    rst_n = 1'b0;
    fail_cnt = 0;
    n_checked = 0;
    n_sent = 0;
    cmd_seen = '{0, 0, 0, 0};
    n_hit = 0;
    n_err = 0;
    n_ovf = 0;
    n_full_dump = 0;
    shadow_count = 0;
    hold_token = 1'b0;
    hold_seen = 1'b0;
    hold_left = 0;
    cycle_cnt = 0;
    src_idle_pct = 20;
    sink_stall_pct = 20;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (k = 2; k < 20; k++) key_pool[k] = KEY_W'($urandom);

    // directed table
    add_row(CMD_DUMP,   10'd0,    15'd0,     15'd0,     1'b1,
            mk_res(16'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    add_row(CMD_RENAME, 10'd0,    15'd0,     15'd0,     1'b1,
            mk_res(16'd1, 1'b0, 1'b0, 1'b0, 1'b0));
    add_row(CMD_MARK,   10'd1023, 15'd32767, 15'd32767, 1'b1,
            mk_res(16'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    add_row(CMD_RENAME, 10'd1023, 15'd32767, 15'd0,     1'b1,
            mk_res(16'd32768, 1'b1, 1'b0, 1'b0, 1'b0));
    // rename below the stored lowest number
    add_row(CMD_RENAME, 10'd1023, 15'd100,   15'd0,     1'b1,
            mk_res(16'd0, 1'b1, 1'b1, 1'b0, 1'b0));
    add_row(CMD_MARK,   10'd1023, 15'd5,     15'd0,     1'b1,
            mk_res(16'd0, 1'b1, 1'b0, 1'b0, 1'b0));
    add_row(CMD_RENAME, 10'd1023, 15'd32767, 15'd0,     1'b0, '0);
    add_row(CMD_RENAME, 10'd512,  15'd0,     15'd32767, 1'b1,
            mk_res(16'd32768, 1'b0, 1'b0, 1'b0, 1'b0));
    for (k = 0; k < TABLE_DEPTH - 3; k++)
      add_row(CMD_MARK, 10'd100 + k[9:0], SSA_W'($urandom), SSA_W'($urandom), 1'b0, '0);
    // table full: inserts are dropped
    add_row(CMD_MARK,   10'd777,  15'd40,    15'd2,     1'b1,
            mk_res(16'd0, 1'b0, 1'b0, 1'b1, 1'b0));
    add_row(CMD_RENAME, 10'd778,  15'd3,     15'd9,     1'b1,
            mk_res(16'd0, 1'b0, 1'b0, 1'b1, 1'b0));
    add_row(CMD_DUMP,   10'd0,    15'd0,     15'd0,     1'b0, '0);
    add_row(CMD_CLEAR,  10'd0,    15'd0,     15'd0,     1'b1,
            mk_res(16'd0, 1'b0, 1'b0, 1'b0, 1'b0));
    add_row(CMD_DUMP,   10'd0,    15'd0,     15'd0,     1'b1,
            mk_res(16'd0, 1'b0, 1'b0, 1'b0, 1'b0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].ssa, dir_rows[i].oldc);
      rename_predict(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].ssa, dir_rows[i].oldc,
                     !dir_rows[i].typed);
      if (dir_rows[i].typed) pending_results.insert(pending_results.size(), dir_rows[i].want);
    end

    for (p = 0; p < NPH; p++) begin
      src_idle_pct = ph_src[p];
      sink_stall_pct <= ph_sink[p];
      // last phase: receiver blocks for a long stretch while commands keep coming
      if (p == NPH - 1) hold_token <= ~hold_token;
      for (k = 0; k < ph_items[p]; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 5)       c = CMD_CLEAR;
        else if (roll < 17) c = CMD_DUMP;
        else if (roll < 55) c = CMD_MARK;
        else                c = CMD_RENAME;
        key = ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, 19)]
                                          : KEY_W'($urandom);
        slot = find_slot(key);
        roll = $urandom_range(0, 99);
        if (roll < 5)       ssa = '0;
        else if (roll < 10) ssa = '1;
        else if (slot >= 0 && roll < 75)
          ssa = SSA_W'(shadow_start[slot] + $urandom_range(0, 32767 - shadow_start[slot]));
        else                ssa = SSA_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 5)       oldc = '0;
        else if (roll < 10) oldc = '1;
        else                oldc = SSA_W'($urandom);
        send_cmd(c, key, ssa, oldc);
        rename_predict(c, key, ssa, oldc, 1'b1);
      end
      // sender pauses until the table has answered everything
      in_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d commands (mark %0d, rename %0d, clear %0d, dump %0d), %0d results checked.",
             n_sent, cmd_seen[CMD_MARK], cmd_seen[CMD_RENAME], cmd_seen[CMD_CLEAR],
             cmd_seen[CMD_DUMP], n_checked);
    $display("Hits %0d, order errors %0d, overflows %0d, full-table dumps %0d.",
             n_hit, n_err, n_ovf, n_full_dump);
    if (fail_cnt == 0) begin
      $display("ssa_rename_table_core regression: pass");
    end else begin
      $display("ssa_rename_table_core regression: fail");
    end
    $finish;
  end

endmodule

// File: ssa_rename_table_core.f
rtl/srt_pkg.sv
rtl/srt_table.sv
rtl/srt_alu.sv
rtl/ssa_rename_table_core.sv
verif/ssa_rename_table_core_test.sv
